FILE: rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants, types and helpers of the line rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

	localparam int CANVAS_SIZE = 64;
	localparam int COORD_W     = 6;
	localparam int COLOR_W     = 8;
	localparam int INC_W       = COORD_W + 1;
	localparam int ERR_W       = COORD_W + 3;

	localparam logic [COORD_W-1:0] LAST_COUNT = COORD_W'(CANVAS_SIZE - 1);

	typedef logic [COORD_W-1:0] coord_t;
	typedef logic [COLOR_W-1:0] color_t;

	typedef struct packed {
		logic load;
		logic step;
	} lr_ctrl_t;

	typedef struct packed {
		logic last;
	} lr_stat_t;

	function automatic coord_t lr_clamp(input coord_t v);
		coord_t c;
		c = v;
		if ({1'b0, v} >= (COORD_W + 1)'(CANVAS_SIZE))
			c = COORD_W'(CANVAS_SIZE - 1);
		return c;
	endfunction

	function automatic coord_t lr_span(input coord_t a, input coord_t b);
		coord_t s;
		s = (a > b) ? (a - b) : (b - a);
		return s;
	endfunction

endpackage

FILE: rtl/lr_cmd_if.sv
// ----------------------------------------------------------------------------
// lr_cmd_if
// Line command channel: two endpoints and a color, valid/ready handshake.
// ----------------------------------------------------------------------------
interface lr_cmd_if import lr_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t x_start;
	coord_t y_start;
	coord_t x_end;
	coord_t y_end;
	color_t line_color;

	modport source (output valid, x_start, y_start, x_end, y_end, line_color, input ready);
	modport sink   (input valid, x_start, y_start, x_end, y_end, line_color, output ready);
endinterface

FILE: rtl/lr_pix_if.sv
// ----------------------------------------------------------------------------
// lr_pix_if
// Pixel channel: one pixel word per handshake, last pixel of a line flagged.
// ----------------------------------------------------------------------------
interface lr_pix_if import lr_pkg::*; ();
	logic   valid;
	logic   ready;
	coord_t pixel_x;
	coord_t pixel_y;
	color_t pixel_color;
	logic   last_pixel;

	modport source (output valid, pixel_x, pixel_y, pixel_color, last_pixel, input ready);
	modport sink   (input valid, pixel_x, pixel_y, pixel_color, last_pixel, output ready);
endinterface

FILE: rtl/lr_datapath.sv
// ----------------------------------------------------------------------------
// lr_datapath
// Line setup, Bresenham walk registers and the pixel output register.
// ----------------------------------------------------------------------------
module lr_datapath
	import lr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  lr_ctrl_t ctrl,
	input  coord_t   x_start,
	input  coord_t   y_start,
	input  coord_t   x_end,
	input  coord_t   y_end,
	input  color_t   line_color,
	output coord_t   pixel_x,
	output coord_t   pixel_y,
	output color_t   pixel_color,
	output logic     last_pixel,
	output lr_stat_t stat
);

	logic                    steep_q;
	logic                    down_q;
	coord_t                  major_q;
	coord_t                  stop_q;
	coord_t                  minor_q;
	coord_t                  span_q;
	logic [INC_W-1:0]        inc_q;
	logic signed [ERR_W-1:0] err_q;
	color_t                  color_q;
	coord_t                  count_q;

	coord_t pix_x_q;
	coord_t pix_y_q;
	color_t pix_color_q;
	logic   pix_last_q;

	// setup
	coord_t xa, ya, xb, yb;
	coord_t ma, na, mb, nb;
	logic   steep_d;

	always_comb begin
		xa      = lr_clamp(x_start);
		ya      = lr_clamp(y_start);
		xb      = lr_clamp(x_end);
		yb      = lr_clamp(y_end);
		steep_d = lr_span(xa, xb) < lr_span(ya, yb);
		if (steep_d) begin
			ma = ya; na = xa; mb = yb; nb = xb;
		end else begin
			ma = xa; na = ya; mb = xb; nb = yb;
		end
		if (ma > mb) begin
			ma = steep_d ? yb : xb;
			na = steep_d ? xb : yb;
			mb = steep_d ? ya : xa;
			nb = steep_d ? xa : ya;
		end
	end

	// walk step
	logic signed [ERR_W-1:0] span_ext;
	logic signed [ERR_W-1:0] err_sum;
	logic                    minor_move;
	logic                    last_now;

	always_comb begin
		span_ext   = $signed({{(ERR_W-COORD_W){1'b0}}, span_q});
		err_sum    = err_q + $signed({{(ERR_W-INC_W){1'b0}}, inc_q});
		minor_move = err_sum > span_ext;
		last_now   = (major_q == stop_q) || (count_q == LAST_COUNT);
	end

	assign stat.last = last_now;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steep_q <= 1'b0;
			down_q  <= 1'b0;
			major_q <= '0;
			stop_q  <= '0;
			minor_q <= '0;
			span_q  <= '0;
			inc_q   <= '0;
			err_q   <= '0;
			color_q <= '0;
			count_q <= '0;
		end else if (ctrl.load) begin
			steep_q <= steep_d;
			down_q  <= !(nb > na);
			major_q <= ma;
			stop_q  <= mb;
			minor_q <= na;
			span_q  <= mb - ma;
			inc_q   <= {lr_span(na, nb), 1'b0};
			err_q   <= '0;
			color_q <= line_color;
			count_q <= '0;
		end else if (ctrl.step) begin
			if (minor_move) begin
				minor_q <= down_q ? (minor_q - 1'b1) : (minor_q + 1'b1);
				err_q   <= err_sum - (span_ext <<< 1);
			end else begin
				err_q   <= err_sum;
			end
			if (!last_now) begin
				major_q <= major_q + 1'b1;
				count_q <= count_q + 1'b1;
			end
		end
	end

	// pixel output register
	always_ff @(posedge clk) begin
		if (ctrl.step) begin
			pix_x_q     <= steep_q ? minor_q : major_q;
			pix_y_q     <= steep_q ? major_q : minor_q;
			pix_color_q <= color_q;
			pix_last_q  <= last_now;
		end
	end

	assign pixel_x     = pix_x_q;
	assign pixel_y     = pix_y_q;
	assign pixel_color = pix_color_q;
	assign last_pixel  = pix_last_q;

	a_load_clears: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> (err_q == '0) && (count_q == '0))
		else $error("walk not cleared on load");

	a_err_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(err_q <= span_ext) && (err_q >= -span_ext))
		else $error("error term out of range");

	a_major_adv: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step && !ctrl.load && !last_now) |=> major_q == $past(major_q) + 1'b1)
		else $error("major axis did not advance");

endmodule

FILE: rtl/lr_controller.sv
// ----------------------------------------------------------------------------
// lr_controller
// Command acceptance and pixel pacing state machine.
// ----------------------------------------------------------------------------
module lr_controller
	import lr_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	output logic     cmd_ready,
	output logic     pix_valid,
	input  logic     pix_ready,
	output lr_ctrl_t ctrl,
	input  lr_stat_t stat
);

	localparam logic S_IDLE = 1'b0;
	localparam logic S_DRAW = 1'b1;

	logic state_q;
	logic valid_q;

	always_comb begin
		cmd_ready = (state_q == S_IDLE);
		ctrl.load = cmd_valid && cmd_ready;
		ctrl.step = (state_q == S_DRAW) && (!valid_q || pix_ready);
	end

	assign pix_valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (ctrl.load)
						state_q <= S_DRAW;
				end
				S_DRAW: begin
					if (ctrl.step && stat.last)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
			if (ctrl.step)
				valid_q <= 1'b1;
			else if (pix_ready)
				valid_q <= 1'b0;
		end
	end

	a_accept_draw: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.load |=> state_q == S_DRAW)
		else $error("accepted word did not start drawing");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.step && stat.last) |=> (state_q == S_IDLE) && valid_q)
		else $error("last pixel did not end the line");

endmodule

FILE: rtl/line_rasterizer_top.sv
// ----------------------------------------------------------------------------
// line_rasterizer_top
// Bresenham line rasterizer on a 64 by 64 canvas, one pixel word per cycle
// while the pixel port is not stalled. The first pixel is registered into the
// output after the command word is accepted and the draw state is entered.
// Throughput: one pixel per cycle from the walk register with no stalls; a
// line of major span N gives N + 1 pixels.
// The next command is taken while the last pixel still waits in the output.
// Reset: arst_n clears the state machine, output valid and the walk registers.
// ----------------------------------------------------------------------------
module line_rasterizer_top
	import lr_pkg::*;
(
	input logic   clk,
	input logic   arst_n,
	lr_cmd_if.sink   cmd,
	lr_pix_if.source pix
);

	lr_ctrl_t ctrl;
	lr_stat_t stat;

	lr_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd.valid),
		.cmd_ready (cmd.ready),
		.pix_valid (pix.valid),
		.pix_ready (pix.ready),
		.ctrl      (ctrl),
		.stat      (stat)
	);

	lr_datapath u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.x_start     (cmd.x_start),
		.y_start     (cmd.y_start),
		.x_end       (cmd.x_end),
		.y_end       (cmd.y_end),
		.line_color  (cmd.line_color),
		.pixel_x     (pix.pixel_x),
		.pixel_y     (pix.pixel_y),
		.pixel_color (pix.pixel_color),
		.last_pixel  (pix.last_pixel),
		.stat        (stat)
	);

endmodule

FILE: tb/sv/line_rasterizer_top_tb.sv
// ----------------------------------------------------------------------------
// line_rasterizer_top_tb
// Self-checking bench for the Bresenham line rasterizer. A short table of
// line commands (corners, full-canvas spans, both walk directions, steep and
// shallow, equal spans) is followed by random commands, mostly short lines.
// Each accepted command is expanded into its pixel words by a local line
// walker, or typed in for single points; every pixel word from the block is
// compared in order. Both ports stall randomly, but not in the last of three phases.
// ----------------------------------------------------------------------------
module line_rasterizer_top_tb;
	import lr_pkg::*;

	localparam int CYCLE_LIMIT      = 600000;
	localparam int RANDOM_PER_PHASE = 153;
	localparam int MAX_PRINTS       = 40;

	typedef struct packed {
		coord_t x0;
		coord_t y0;
		coord_t x1;
		coord_t y1;
		color_t color;
	} line_t;

	typedef struct packed {
		coord_t x;
		coord_t y;
		color_t color;
		logic   last;
	} pixel_t;

	typedef struct packed {
		line_t  cmd;
		logic   typed;
		pixel_t pix;
	} line_row_t;

	localparam pixel_t NO_PIX = '0;

	logic clk;
	logic arst_n;

	lr_cmd_if cmd ();
	lr_pix_if pix ();

	line_rasterizer_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.pix    (pix)
	);

	pixel_t    pending_pixels [$];
	line_row_t line_rows [$];
	int        mismatches;
	int        send_idle;
	int        recv_idle;
	int        cycle_count;

	// single points carry their one pixel word typed in
	line_row_t directed_rows [18] = '{
		'{'{ 0,  0,  0,  0, 8'h00}, 1'b1, '{ 0,  0, 8'h00, 1'b1}},
		'{'{63, 63, 63, 63, 8'hFF}, 1'b1, '{63, 63, 8'hFF, 1'b1}},
		'{'{ 0, 63,  0, 63, 8'hA5}, 1'b1, '{ 0, 63, 8'hA5, 1'b1}},
		'{'{63,  0, 63,  0, 8'h5A}, 1'b1, '{63,  0, 8'h5A, 1'b1}},
		'{'{ 0,  0, 63,  0, 8'h01}, 1'b0, NO_PIX},
		'{'{63, 63,  0, 63, 8'h80}, 1'b0, NO_PIX},
		'{'{ 0,  0,  0, 63, 8'h7F}, 1'b0, NO_PIX},
		'{'{63, 63, 63,  0, 8'hFE}, 1'b0, NO_PIX},
		'{'{ 0,  0, 63, 63, 8'h33}, 1'b0, NO_PIX},
		'{'{63,  0,  0, 63, 8'hCC}, 1'b0, NO_PIX},
		'{'{ 5,  9,  1,  5, 8'h10}, 1'b0, NO_PIX},
		'{'{10,  0, 20, 63, 8'h20}, 1'b0, NO_PIX},
		'{'{40,  5, 30, 60, 8'h40}, 1'b0, NO_PIX},
		'{'{ 2, 50, 60, 41, 8'h08}, 1'b0, NO_PIX},
		'{'{60, 10,  3, 17, 8'h02}, 1'b0, NO_PIX},
		'{'{ 0,  0, 62, 63, 8'h04}, 1'b0, NO_PIX},
		'{'{ 0,  0, 63, 62, 8'h0F}, 1'b0, NO_PIX},
		'{'{31, 31, 32, 32, 8'hF0}, 1'b0, NO_PIX}
	};

	function automatic int abs_diff(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// walk the line and queue every pixel word it gives
	function automatic void plot_line(input line_t c);
		coord_t major, major_stop, minor, minor_end, t;
		bit     steep, step_down;
		int     span, incr, err_acc, n;
		pixel_t p;
		steep = abs_diff(c.x0, c.x1) < abs_diff(c.y0, c.y1);
		if (steep) begin
			major = c.y0; minor = c.x0; major_stop = c.y1; minor_end = c.x1;
		end else begin
			major = c.x0; minor = c.y0; major_stop = c.x1; minor_end = c.y1;
		end
		if (major > major_stop) begin
			t = major; major = major_stop; major_stop = t;
			t = minor; minor = minor_end; minor_end = t;
		end
		span      = int'(major_stop) - int'(major);
		incr      = 2 * abs_diff(minor, minor_end);
		step_down = !(minor_end > minor);
		err_acc   = 0;
		for (n = 0; n < CANVAS_SIZE; n++) begin
			p.x     = steep ? minor : major;
			p.y     = steep ? major : minor;
			p.color = c.color;
			p.last  = (major == major_stop) || (n == CANVAS_SIZE - 1);
			pending_pixels.push_back(p);
			err_acc += incr;
			if (err_acc > span) begin
				minor   = step_down ? minor - 1'b1 : minor + 1'b1;
				err_acc -= 2 * span;
			end
			if (p.last)
				break;
			major = major + 1'b1;
		end
	endfunction

	function automatic int clip_coord(input int v);
		return (v < 0) ? 0 : ((v > CANVAS_SIZE - 1) ? CANVAS_SIZE - 1 : v);
	endfunction

	function automatic line_t random_line();
		line_t l;
		int    kind, d;
		l.x0    = coord_t'($urandom);
		l.y0    = coord_t'($urandom);
		l.x1    = coord_t'($urandom);
		l.y1    = coord_t'($urandom);
		l.color = color_t'($urandom);
		kind = $urandom_range(99);
		if (kind < 60) begin
			l.x1 = coord_t'(clip_coord(int'(l.x0) + int'($urandom_range(16)) - 8));
			l.y1 = coord_t'(clip_coord(int'(l.y0) + int'($urandom_range(16)) - 8));
		end else if (kind < 80) begin
		end else if (kind < 85) begin
			l.x1 = l.x0;
			l.y1 = l.y0;
		end else if (kind < 90) begin
			l.y1 = l.y0;
		end else if (kind < 95) begin
			l.x1 = l.x0;
		end else begin
			d = abs_diff(l.x0, l.x1);
			if (int'(l.y0) + d <= CANVAS_SIZE - 1)
				l.y1 = coord_t'(int'(l.y0) + d);
			else if (int'(l.y0) >= d)
				l.y1 = coord_t'(int'(l.y0) - d);
		end
		return l;
	endfunction

	task automatic report_mismatch(input string msg);
		if (mismatches < MAX_PRINTS)
			$display("mismatch at cycle %0d: %s", cycle_count, msg);
		mismatches++;
	endtask

	task automatic send_line(input line_row_t row);
		if ($urandom_range(99) < send_idle) begin
			cmd.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle);
		end
		line_rows.push_back(row);
		cmd.valid      <= 1'b1;
		cmd.x_start    <= row.cmd.x0;
		cmd.y_start    <= row.cmd.y0;
		cmd.x_end      <= row.cmd.x1;
		cmd.y_end      <= row.cmd.y1;
		cmd.line_color <= row.cmd.color;
		do @(posedge clk); while (!cmd.ready);
	endtask

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		pix.ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	always @(posedge clk) begin : pixel_check
		line_row_t row;
		pixel_t    want;
		if (arst_n) begin
			if (cmd.valid && cmd.ready && line_rows.size() != 0) begin
				row = line_rows.pop_front();
				if (row.typed)
					pending_pixels.push_back(row.pix);
				else
					plot_line(row.cmd);
			end
			if (pix.valid && pix.ready) begin
				if (pending_pixels.size() == 0) begin
					report_mismatch($sformatf("pixel word (%0d,%0d) with none pending",
						pix.pixel_x, pix.pixel_y));
				end else begin
					want = pending_pixels.pop_front();
					if (pix.pixel_x !== want.x)
						report_mismatch($sformatf("pixel_x got %0d want %0d",
							pix.pixel_x, want.x));
					if (pix.pixel_y !== want.y)
						report_mismatch($sformatf("pixel_y got %0d want %0d",
							pix.pixel_y, want.y));
					if (pix.pixel_color !== want.color)
						report_mismatch($sformatf("pixel_color got %0h want %0h",
							pix.pixel_color, want.color));
					if (pix.last_pixel !== want.last)
						report_mismatch($sformatf("last_pixel got %0b want %0b at (%0d,%0d)",
							pix.last_pixel, want.last, want.x, want.y));
				end
			end
		end
	end

	initial begin
		line_row_t row;
		arst_n         = 1'b0;
		cmd.valid      = 1'b0;
		cmd.x_start    = '0;
		cmd.y_start    = '0;
		cmd.x_end      = '0;
		cmd.y_end      = '0;
		cmd.line_color = '0;
		send_idle      = 29;
		recv_idle      = 50;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		foreach (directed_rows[i])
			send_line(directed_rows[i]);
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 29;
					recv_idle = 50;
				end
				1: begin
					send_idle = 50;
					recv_idle = 29;
				end
				default: begin
					send_idle = 0;
					recv_idle = 0;
				end
			endcase
			repeat (RANDOM_PER_PHASE) begin
				row.cmd   = random_line();
				row.typed = 1'b0;
				row.pix   = NO_PIX;
				send_line(row);
			end
		end
		cmd.valid <= 1'b0;
		while (pending_pixels.size() != 0 || line_rows.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
